/* hw/rtl/b64sc_pkg.sv */
// b64sc_pkg: shared job type and alphabet mapping for the base64 stream codec
// no dependencies; used by every module of the codec

package b64sc_pkg;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one burst of results: left-aligned group, direction, last index and last real-character index
    typedef struct packed {
        logic [23:0] bits;
        logic        dec;
        logic [1:0]  cnt;
        logic [1:0]  real_last;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = CHAR_UPPER + {2'b00, v};
        end else if (v < 6'd52) begin
            c = CHAR_LOWER + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = CHAR_DIGIT + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    // returns {valid, sextet}
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'h00;
        r = 7'h00;
        if (c >= CHAR_UPPER && c <= 8'h5A) begin
            d = c - CHAR_UPPER;
            r = {1'b1, d[5:0]};
        end else if (c >= CHAR_LOWER && c <= 8'h7A) begin
            d = c - CHAR_LOWER + 8'd26;
            r = {1'b1, d[5:0]};
        end else if (c >= CHAR_DIGIT && c <= 8'h39) begin
            d = c - CHAR_DIGIT + 8'd52;
            r = {1'b1, d[5:0]};
        end else if (c == CHAR_PLUS) begin
            r = {1'b1, 6'd62};
        end else if (c == CHAR_SLASH) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/b64sc_front.sv */
// b64sc_front: accepts items, keeps group state and direction, builds output jobs
// depends on b64sc_pkg

module b64sc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_has_byte,
    input  logic               s_end_of_message,
    input  logic               q_full,
    output logic               push_valid,
    output b64sc_pkg::job_t    push_job
);

    logic        dir_reg;
    logic [23:0] gb_reg, gb_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        halted_reg, halted_next;

    logic [2:0]  cnt_step;
    logic [6:0]  sx;
    logic        job_v;
    b64sc_pkg::job_t job;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        gb_next     = gb_reg;
        cnt_step    = {1'b0, cnt_reg};
        halted_next = halted_reg;
        job_v       = 1'b0;
        job         = '0;
        sx          = b64sc_pkg::char_sextet(s_data_byte);

        if (s_has_byte) begin
            if (dir_reg == b64sc_pkg::DIR_ENCODE) begin
                gb_next  = {gb_reg[15:0], s_data_byte};
                cnt_step = {1'b0, cnt_reg} + 3'd1;
                if (cnt_step >= 3'd3) begin
                    job_v         = 1'b1;
                    job.bits      = gb_next;
                    job.dec       = b64sc_pkg::DIR_ENCODE;
                    job.cnt       = 2'd3;
                    job.real_last = 2'd3;
                    gb_next       = '0;
                    cnt_step      = '0;
                end
            end else if (!halted_reg) begin
                if (!sx[6]) begin
                    halted_next = 1'b1;
                end else begin
                    gb_next  = {gb_reg[17:0], sx[5:0]};
                    cnt_step = {1'b0, cnt_reg} + 3'd1;
                    if (cnt_step == 3'd4) begin
                        job_v         = 1'b1;
                        job.bits      = gb_next;
                        job.dec       = b64sc_pkg::DIR_DECODE;
                        job.cnt       = 2'd2;
                        job.real_last = 2'd2;
                        gb_next       = '0;
                        cnt_step      = '0;
                    end
                end
            end
        end

        if (s_end_of_message) begin
            if (dir_reg == b64sc_pkg::DIR_ENCODE) begin
                job.dec = b64sc_pkg::DIR_ENCODE;
                job.cnt = 2'd3;
                case (cnt_step[1:0])
                    2'd1: begin
                        job_v         = 1'b1;
                        job.bits      = {gb_next[7:0], 16'h0000};
                        job.real_last = 2'd1;
                    end
                    2'd2: begin
                        job_v         = 1'b1;
                        job.bits      = {gb_next[15:0], 8'h00};
                        job.real_last = 2'd2;
                    end
                    2'd3: begin
                        job_v         = 1'b1;
                        job.bits      = gb_next;
                        job.real_last = 2'd3;
                    end
                    default: begin
                    end
                endcase
            end else begin
                job.dec = b64sc_pkg::DIR_DECODE;
                case (cnt_step[1:0])
                    2'd2: begin
                        job_v         = 1'b1;
                        job.bits      = {gb_next[11:0], 12'h000};
                        job.cnt       = 2'd0;
                        job.real_last = 2'd0;
                    end
                    2'd3: begin
                        job_v         = 1'b1;
                        job.bits      = {gb_next[17:0], 6'h00};
                        job.cnt       = 2'd1;
                        job.real_last = 2'd1;
                    end
                    default: begin
                    end
                endcase
            end
            gb_next     = '0;
            cnt_step    = '0;
            halted_next = 1'b0;
        end
        cnt_next = cnt_step[1:0];
    end

    assign push_valid = accept && job_v;
    assign push_job   = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg    <= b64sc_pkg::DIR_ENCODE;
            gb_reg     <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                dir_reg <= cfg_data;
            end
            if (accept) begin
                gb_reg     <= gb_next;
                cnt_reg    <= cnt_next;
                halted_reg <= halted_next;
            end
        end
    end

endmodule

/* hw/rtl/b64sc_queue.sv */
// b64sc_queue: short job queue between front and back
// depends on b64sc_pkg

module b64sc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  b64sc_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output b64sc_pkg::job_t head_job
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64sc_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/b64sc_back.sv */
// b64sc_back: walks the head job one result per cycle into the output register while m_ready does not stall it
// depends on b64sc_pkg

module b64sc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  b64sc_pkg::job_t head_job,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    logic [1:0] k_reg, k_next;
    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       load;
    logic       last;
    logic [5:0] six;
    logic [7:0] dbyte;
    logic [7:0] res;

    assign load = head_valid && (!m_valid_reg || m_ready);
    assign last = (k_reg == head_job.cnt);
    assign pop  = load && last;

    always_comb begin
        case (k_reg)
            2'd0: begin
                six   = head_job.bits[23:18];
                dbyte = head_job.bits[23:16];
            end
            2'd1: begin
                six   = head_job.bits[17:12];
                dbyte = head_job.bits[15:8];
            end
            2'd2: begin
                six   = head_job.bits[11:6];
                dbyte = head_job.bits[7:0];
            end
            default: begin
                six   = head_job.bits[5:0];
                dbyte = head_job.bits[7:0];
            end
        endcase
        if (head_job.dec == b64sc_pkg::DIR_DECODE) begin
            res = dbyte;
        end else if (k_reg <= head_job.real_last) begin
            res = b64sc_pkg::sextet_char(six);
        end else begin
            res = b64sc_pkg::CHAR_PAD;
        end
        k_next = last ? 2'd0 : k_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= res;
            last_reg <= last;
        end
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                k_reg       <= k_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

    a_enc_four : assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_job.dec == b64sc_pkg::DIR_ENCODE) |-> head_job.cnt == 2'd3)
        else $error("encode job without four results");

    a_dec_max_three : assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_job.dec == b64sc_pkg::DIR_DECODE) |-> head_job.cnt != 2'd3)
        else $error("decode job with four results");

    a_k_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> k_reg <= head_job.cnt)
        else $error("result index beyond job length");

    a_k_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> k_reg == 2'd0)
        else $error("result index left over with no job");

endmodule

/* hw/rtl/base64_stream_codec_unit.sv */
// base64_stream_codec_unit: top level of the base64 stream codec
// depends on b64sc_pkg, b64sc_front, b64sc_queue, b64sc_back
//
// Byte-stream base64 codec; cfg_data sets the direction (0 encode, 1 decode). The user must
// write it only while the block is idle; the block itself does not enforce this. The front
// takes one input item per cycle whenever the job queue (QUEUE_DEPTH entries) has room, and
// turns each item that produces output into one job. The back drains jobs through the
// output register at one result byte per cycle while m_ready does not stall it; a job is
// registered in the queue before its first result is loaded into the output register. An
// encoded group of three bytes gives four result bytes, so the output limits encode input.

module base64_stream_codec_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_has_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    logic            q_full;
    logic            push_valid;
    b64sc_pkg::job_t push_job;
    logic            pop;
    logic            head_valid;
    b64sc_pkg::job_t head_job;

    assign cfg_ready = 1'b1;

    b64sc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .q_full           (q_full),
        .push_valid       (push_valid),
        .push_job         (push_job)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64sc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

/* verif/base64_stream_codec_checker.sv */
`timescale 1ns / 100ps
// base64_stream_codec_checker: watches the config, input and result channels of the codec,
// predicts the result items of every accepted input item and compares them in order
// depends on b64sc_pkg for the direction codes and the pad character

module base64_stream_codec_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_has_byte,
    input  logic       s_end_of_message,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_last_of_run,
    output int         fail_count,
    output int         pending_results
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } codec_result_t;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic [23:0]   group_bits;
    int            group_count;
    logic          decode_halted;
    logic          direction;
    codec_result_t expected_q[$];
    codec_result_t want;

    function automatic logic [7:0] char_of(input logic [5:0] v);
        int pos;
        pos = 8 * (63 - int'(v));
        return ALPHABET[pos +: 8];
    endfunction

    // -1 for anything outside the alphabet
    function automatic int sextet_of(input logic [7:0] c);
        int v;
        v = -1;
        for (int k = 0; k < 64; k++) begin
            if (char_of(k[5:0]) == c) begin
                v = k;
            end
        end
        return v;
    endfunction

    task automatic codec_step(input logic [7:0] data, input logic has, input logic eom);
        logic [7:0]    burst [4];
        int            nb;
        codec_result_t res;
        logic [23:0]   aligned;
        logic [5:0]    sx;
        int            v;
        nb = 0;
        if (has) begin
            if (direction == b64sc_pkg::DIR_ENCODE) begin
                group_bits = {group_bits[15:0], data};
                group_count++;
                if (group_count >= 3) begin
                    for (int k = 0; k < 4; k++) begin
                        burst[nb] = char_of(group_bits[18 - 6 * k +: 6]);
                        nb++;
                    end
                    group_bits = '0;
                    group_count = 0;
                end
            end else if (!decode_halted) begin
                v = sextet_of(data);
                if (v < 0) begin
                    decode_halted = 1'b1;
                end else begin
                    sx = v[5:0];
                    group_bits = {group_bits[17:0], sx};
                    group_count++;
                    if (group_count >= 4) begin
                        for (int k = 0; k < 3; k++) begin
                            burst[nb] = group_bits[16 - 8 * k +: 8];
                            nb++;
                        end
                        group_bits = '0;
                        group_count = 0;
                    end
                end
            end
        end
        if (eom) begin
            if (group_count > 0) begin
                if (direction == b64sc_pkg::DIR_ENCODE) begin
                    aligned = group_bits << (8 * (3 - group_count));
                    for (int k = 0; k <= group_count; k++) begin
                        burst[nb] = char_of(aligned[18 - 6 * k +: 6]);
                        nb++;
                    end
                    for (int p = group_count; p < 3; p++) begin
                        burst[nb] = b64sc_pkg::CHAR_PAD;
                        nb++;
                    end
                end else begin
                    aligned = group_bits << (6 * (4 - group_count));
                    for (int k = 0; k < group_count - 1; k++) begin
                        burst[nb] = aligned[16 - 8 * k +: 8];
                        nb++;
                    end
                end
            end
            group_bits = '0;
            group_count = 0;
            decode_halted = 1'b0;
        end
        for (int k = 0; k < nb; k++) begin
            res.out_byte = burst[k];
            res.last_of_run = (k == nb - 1);
            expected_q.insert(expected_q.size(), res);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            group_bits = '0;
            group_count = 0;
            decode_halted = 1'b0;
            direction = b64sc_pkg::DIR_ENCODE;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                direction = cfg_data;
            end
            if (s_valid && s_ready) begin
                codec_step(s_data_byte, s_has_byte, s_end_of_message);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got out_byte %02h last %0b",
                             $time, m_out_byte, m_last_of_run);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.out_byte, m_out_byte);
                        fail_count++;
                    end
                    if (m_last_of_run !== want.last_of_run) begin
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, want.last_of_run, m_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
        pending_results = expected_q.size();
    end

endmodule

/* verif/tb_base64_stream_codec_unit.sv */
`timescale 1ns / 100ps
// tb_base64_stream_codec_unit: drives directed and random messages in both directions
// with random gaps and stalls and gives the verdict from the checker's failure count
// depends on b64sc_pkg, base64_stream_codec_unit and base64_stream_codec_checker

module tb_base64_stream_codec_unit;

    localparam int CYCLE_LIMIT = 500000;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_has_byte;
    logic       s_end_of_message;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    int   stall_left;
    int   sent_items;
    logic steady;

    base64_stream_codec_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_of_run    (m_last_of_run)
    );

    base64_stream_codec_checker u_watch (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_of_run    (m_last_of_run),
        .fail_count       (fail_count),
        .pending_results  (pending_results)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] alpha_char();
        logic [7:0] off;
        case ($urandom_range(0, 3))
            0: begin
                off = 8'($urandom_range(0, 25));
                return b64sc_pkg::CHAR_UPPER + off;
            end
            1: begin
                off = 8'($urandom_range(0, 25));
                return b64sc_pkg::CHAR_LOWER + off;
            end
            2: begin
                off = 8'($urandom_range(0, 9));
                return b64sc_pkg::CHAR_DIGIT + off;
            end
            default: begin
                return $urandom_range(0, 1) ? b64sc_pkg::CHAR_PLUS : b64sc_pkg::CHAR_SLASH;
            end
        endcase
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = 8'($urandom_range(8'h80, 8'hff));
            1: c = 8'($urandom_range(8'h00, 8'h2a));
            2: c = 8'($urandom_range(8'h2c, 8'h2e));
            3: c = 8'($urandom_range(8'h3a, 8'h40));
            4: c = 8'($urandom_range(8'h5b, 8'h60));
            default: c = 8'($urandom_range(8'h7b, 8'h7f));
        endcase
        return c;
    endfunction

    // result side: random stalls unless the phase runs steady
    initial begin
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if (!steady && $urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data_byte = data;
        s_has_byte = has;
        s_end_of_message = eom;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic set_direction(input logic dir);
        hold_until_drained();
        // items with no result may still be in flight
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_data = dir;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic encode_message();
        int len;
        bit bare;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 10);
        bare = ($urandom_range(0, 3) == 0) || (len == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, !bare && i == len - 1);
        end
        if (bare) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic decode_message();
        int         len;
        int         pads;
        int         total;
        int         cut;
        bit         bare;
        bit         noise;
        logic [7:0] c;
        noise = $urandom_range(0, 9) == 0;
        len = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
        pads = (len % 4 == 2) ? 2 : (len % 4 == 3) ? 1 : 0;
        if ($urandom_range(0, 4) == 0) begin
            pads = $urandom_range(0, 2);
        end
        total = len + pads;
        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, total) : -1;
        bare = ($urandom_range(0, 3) == 0) || (total == 0);
        for (int i = 0; i < total; i++) begin
            if (noise) begin
                c = 8'($urandom_range(0, 255));
            end else if (i == cut) begin
                c = bad_char();
            end else if (i >= len) begin
                c = b64sc_pkg::CHAR_PAD;
            end else begin
                c = alpha_char();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(c, 1'b1, !bare && i == total - 1);
        end
        if (bare) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        int target;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = b64sc_pkg::DIR_ENCODE;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_has_byte = 1'b0;
        s_end_of_message = 1'b0;
        steady = 1'b0;
        sent_items = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // encode: extremes, idle item, one and two byte tails, bare end on empty group
        set_direction(b64sc_pkg::DIR_ENCODE);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'hfb, 1'b1, 1'b1);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        send_item(8'hc3, 1'b0, 1'b1);
        // two bytes held, then decode carries on with the same group
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        set_direction(b64sc_pkg::DIR_DECODE);
        send_item("Q", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // halted on pad, rest ignored, partial group still flushed
        send_item("Q", 1'b1, 1'b0);
        send_item("U", 1'b1, 1'b0);
        send_item(b64sc_pkg::CHAR_PAD, 1'b1, 1'b0);
        send_item("x", 1'b1, 1'b1);
        // lone character gives nothing
        send_item("g", 1'b1, 1'b1);
        // three characters held, flushed as encode without padding
        send_item("/", 1'b1, 1'b0);
        send_item("+", 1'b1, 1'b0);
        send_item("9", 1'b1, 1'b0);
        set_direction(b64sc_pkg::DIR_ENCODE);
        send_item(8'h00, 1'b0, 1'b1);
        // three characters held, next encode byte emits the group at once
        set_direction(b64sc_pkg::DIR_DECODE);
        send_item("a", 1'b1, 1'b0);
        send_item("0", 1'b1, 1'b0);
        send_item("+", 1'b1, 1'b0);
        set_direction(b64sc_pkg::DIR_ENCODE);
        send_item(8'he7, 1'b1, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            steady = (phase % 3 == 2);
            set_direction(phase % 2 == 0 ? b64sc_pkg::DIR_DECODE : b64sc_pkg::DIR_ENCODE);
            target = sent_items + 32;
            while (sent_items < target) begin
                if (phase % 2 == 0) begin
                    decode_message();
                end else begin
                    encode_message();
                end
                if ($urandom_range(0, 19) == 0) begin
                    hold_until_drained();
                end
            end
        end

        steady = 1'b0;
        hold_until_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
